### sv/qbs_pkg.sv
// Shared types and constants for the quadratic Bezier sampler.
package qbs_pkg;

   // Coordinate and segment count formats
   localparam int COORD_BITS = 16;
   localparam int SEG_BITS   = 6;
   localparam int AXES       = 2;

   // Curve parameter t and its complement, unsigned Q1.16
   localparam int T_BITS = 17;
   localparam logic [T_BITS-1:0] T_ONE = 17'h10000;

   // Weights are unsigned Q1.32, products and sums carry the 2^32 scale
   localparam int W_BITS     = 33;
   localparam int PROD_BITS  = W_BITS + 1 + COORD_BITS;
   localparam int ACC_BITS   = PROD_BITS + 2;
   localparam int FRAC_SHIFT = 32;
   localparam int RES_BITS   = ACC_BITS - FRAC_SHIFT;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(64'sh8000_0000);

   // Clamp limits of a 16-bit signed coordinate, at the width of the rounded sum
   localparam logic signed [RES_BITS-1:0] RES_MAX = RES_BITS'(32767);
   localparam logic signed [RES_BITS-1:0] RES_MIN = -RES_BITS'(32768);

   // The divider forms 2^16 / n, one quotient bit per cycle
   localparam int DIV_STEPS    = T_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic                load;   // capture a new request and start the divider
      logic                issue;  // send the current point into the pipeline
      logic                last;   // the issued point closes the curve
      logic [SEG_BITS-1:0] count;  // effective segment count
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_done;  // step quotient and remainder are ready
      logic pipe_en;   // the pipeline may advance this cycle
      logic busy;      // a point is still inside the pipeline
   } ctrl_status_type;

endpackage

### sv/qbs_intf.sv
// Request and response channel interfaces of the quadratic Bezier sampler.
interface qbs_req_if;
   import qbs_pkg::*;

   logic                valid;
   logic                ready;
   coord_type           start_x;
   coord_type           start_y;
   coord_type           ctrl_x;
   coord_type           ctrl_y;
   coord_type           end_x;
   coord_type           end_y;
   logic [SEG_BITS-1:0] segments;

   modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, segments,
                   input ready);
   modport sink   (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, segments,
                   output ready);
endinterface

interface qbs_rsp_if;
   import qbs_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      last;

   modport source (output valid, point_x, point_y, last, input ready);
   modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

### sv/qbs_div.sv
// Restoring divider that forms 2^16 / n with remainder, one bit per cycle.
module qbs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [qbs_pkg::SEG_BITS-1:0] divisor,
   output logic                         done,
   output logic [qbs_pkg::T_BITS-1:0]   quotient,
   output logic [qbs_pkg::SEG_BITS-1:0] remainder
);
   import qbs_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [T_BITS-1:0]       dvd_ff, dvd_in;
   logic [T_BITS-1:0]       quo_ff, quo_in;
   logic [SEG_BITS-1:0]     rem_ff, rem_in;
   logic [SEG_BITS-1:0]     dsr_ff, dsr_in;
   logic [SEG_BITS:0]       trial;
   logic                    fits;

   // One restoring step: bring down the next dividend bit and try the subtraction.
   always_comb begin
      trial    = {rem_ff, dvd_ff[T_BITS-1]};
      fits     = trial >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS);
         dvd_in  = T_ONE;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[T_BITS-2:0], 1'b0};
         quo_in = {quo_ff[T_BITS-2:0], fits};
         rem_in = fits ? SEG_BITS'(trial - {1'b0, dsr_ff}) : trial[SEG_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags are reset; the working registers are loaded on start.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### sv/qbs_datapath.sv
// Datapath: parameter stepping, weight and blend pipeline, and the response register.
module qbs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  qbs_pkg::ctrl_cmd_type    cmd,
   output qbs_pkg::ctrl_status_type status,
   input  qbs_pkg::coord_type       start_x,
   input  qbs_pkg::coord_type       start_y,
   input  qbs_pkg::coord_type       ctrl_x,
   input  qbs_pkg::coord_type       ctrl_y,
   input  qbs_pkg::coord_type       end_x,
   input  qbs_pkg::coord_type       end_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output qbs_pkg::coord_type       point_x,
   output qbs_pkg::coord_type       point_y,
   output logic                     rsp_last
);
   import qbs_pkg::*;

   // Request coordinates, held for the whole curve
   coord_type s_ff[AXES], c_ff[AXES], e_ff[AXES];

   // Running parameter t = round(i * 2^16 / n) and its remainder
   logic [T_BITS-1:0]   t_ff, t_in;
   logic [SEG_BITS-1:0] trem_ff, trem_in;
   logic [SEG_BITS:0]   rsum;
   logic [T_BITS-1:0]   step_q;
   logic [SEG_BITS-1:0] step_r;
   logic                div_done;

   // Pipeline registers
   logic                      pipe_en;
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                      s1_last_ff, s2_last_ff, s3_last_ff, out_last_ff;
   logic [T_BITS-1:0]         s1_t_ff;
   logic [T_BITS-1:0]         u;
   logic [2*T_BITS-1:0]       uu, ut, tt;
   logic [W_BITS-1:0]         w0_ff, w1_ff, w2_ff;
   logic signed [W_BITS:0]    w0s, w1s, w2s;
   logic signed [PROD_BITS-1:0] p0_in[AXES], p1_in[AXES], p2_in[AXES];
   logic signed [PROD_BITS-1:0] p0_ff[AXES], p1_ff[AXES], p2_ff[AXES];
   logic signed [ACC_BITS-1:0]  acc[AXES];
   logic signed [RES_BITS-1:0]  res[AXES];
   coord_type                   pt_in[AXES], pt_ff[AXES];

   qbs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .divisor   (cmd.count),
      .done      (div_done),
      .quotient  (step_q),
      .remainder (step_r)
   );

   // The whole pipeline moves whenever the response register can take a new point.
   assign pipe_en = !out_valid_ff || rsp_ready;

   // Next t: add the step 2^16 / n and carry the remainder once it reaches n.
   always_comb begin
      rsum    = {1'b0, trem_ff} + {1'b0, step_r};
      t_in    = t_ff;
      trem_in = trem_ff;
      if (cmd.load) begin
         t_in    = '0;
         trem_in = cmd.count >> 1;
      end else if (cmd.issue) begin
         if (rsum >= {1'b0, cmd.count}) begin
            t_in    = t_ff + step_q + 1'b1;
            trem_in = SEG_BITS'(rsum - {1'b0, cmd.count});
         end else begin
            t_in    = t_ff + step_q;
            trem_in = rsum[SEG_BITS-1:0];
         end
      end
   end

   // Weights u*u, 2*u*t and t*t from the registered parameter.
   always_comb begin
      u  = T_ONE - s1_t_ff;
      uu = u * u;
      ut = u * s1_t_ff;
      tt = s1_t_ff * s1_t_ff;
   end

   // Weighted coordinates, one product per weight and axis.
   always_comb begin
      w0s = {1'b0, w0_ff};
      w1s = {1'b0, w1_ff};
      w2s = {1'b0, w2_ff};
      for (int a = 0; a < AXES; a++) begin
         p0_in[a] = w0s * s_ff[a];
         p1_in[a] = w1s * c_ff[a];
         p2_in[a] = w2s * e_ff[a];
      end
   end

   // Sum, round to nearest with ties upwards, drop the 2^32 scale and clamp.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         acc[a] = ACC_BITS'(p0_ff[a]) + ACC_BITS'(p1_ff[a]) + ACC_BITS'(p2_ff[a])
                  + ROUND_BIAS;
         res[a] = acc[a][ACC_BITS-1:FRAC_SHIFT];
         if (res[a] > RES_MAX) begin
            pt_in[a] = coord_type'(RES_MAX);
         end else if (res[a] < RES_MIN) begin
            pt_in[a] = coord_type'(RES_MIN);
         end else begin
            pt_in[a] = res[a][COORD_BITS-1:0];
         end
      end
   end

   // Valid flags of the pipeline and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers of the request, the t stepper and the pipeline.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff[0] <= start_x;
         s_ff[1] <= start_y;
         c_ff[0] <= ctrl_x;
         c_ff[1] <= ctrl_y;
         e_ff[0] <= end_x;
         e_ff[1] <= end_y;
      end
      t_ff    <= t_in;
      trem_ff <= trem_in;
      if (pipe_en) begin
         s1_t_ff     <= t_ff;
         s1_last_ff  <= cmd.last;
         w0_ff       <= uu[W_BITS-1:0];
         w1_ff       <= {ut[W_BITS-2:0], 1'b0};
         w2_ff       <= tt[W_BITS-1:0];
         s2_last_ff  <= s1_last_ff;
         s3_last_ff  <= s2_last_ff;
         out_last_ff <= s3_last_ff;
         for (int a = 0; a < AXES; a++) begin
            p0_ff[a] <= p0_in[a];
            p1_ff[a] <= p1_in[a];
            p2_ff[a] <= p2_in[a];
            pt_ff[a] <= pt_in[a];
         end
      end
   end

   assign status.div_done = div_done;
   assign status.pipe_en  = pipe_en;
   assign status.busy     = s1_valid_ff || s2_valid_ff || s3_valid_ff;

   assign rsp_valid = out_valid_ff;
   assign point_x   = pt_ff[0];
   assign point_y   = pt_ff[1];
   assign rsp_last  = out_last_ff;

endmodule

### sv/qbs_ctrl.sv
// Controller: accepts a request, waits for the step division and issues the points.
module qbs_ctrl #(
   parameter int MAX_SEGMENTS = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [qbs_pkg::SEG_BITS-1:0] req_segments,
   input  qbs_pkg::ctrl_status_type     status,
   output qbs_pkg::ctrl_cmd_type        cmd
);
   import qbs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type           state_ff, state_in;
   logic [SEG_BITS-1:0] idx_ff, idx_in;
   logic [SEG_BITS-1:0] n_ff, n_in;
   logic [SEG_BITS-1:0] n_req;
   logic                accept;
   logic                is_last;

   // A count of zero means one segment; larger counts saturate at the maximum.
   always_comb begin
      if (req_segments == '0) begin
         n_req = SEG_BITS'(1);
      end else if (req_segments > SEG_BITS'(MAX_SEGMENTS)) begin
         n_req = SEG_BITS'(MAX_SEGMENTS);
      end else begin
         n_req = req_segments;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_last   = (idx_ff == n_ff);

   // Commands to the datapath.
   always_comb begin
      cmd.load  = accept;
      cmd.issue = (state_ff == ST_RUN) && status.pipe_en;
      cmd.last  = is_last;
      cmd.count = accept ? n_req : n_ff;
   end

   // Next state and point index.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIVIDE;
               idx_in   = '0;
               n_in     = n_req;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.pipe_en) begin
               if (is_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         n_ff     <= SEG_BITS'(1);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
      end
   end

endmodule

### sv/quadratic_bezier_sampler.sv
// Quadratic Bezier sampler: one request (start, control and end point in signed
// Q12.4, and a segment count n) yields n+1 curve points for t = i/n, i = 0..n, the
// last one flagged; a count of 0 is taken as 1 and counts above MAX_SEGMENTS are
// saturated. After a request is accepted, a bit-serial divider forms 2^16/n, and
// the controller waits in ST_DIVIDE for its done flag before it moves to ST_RUN.
// Points then enter a four-stage weight-and-blend pipeline one per cycle while the
// response side does not stall. The next request is taken once the pipeline has
// emptied. The final response register keeps its point while the next request is
// accepted.
module quadratic_bezier_sampler #(
   parameter int MAX_SEGMENTS = 63
) (
   input logic        clock,
   input logic        reset,
   qbs_req_if.sink    req_chan,
   qbs_rsp_if.source  rsp_chan
);
   import qbs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   qbs_ctrl #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_segments (req_chan.segments),
      .status       (status),
      .cmd          (cmd)
   );

   qbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .start_x   (req_chan.start_x),
      .start_y   (req_chan.start_y),
      .ctrl_x    (req_chan.ctrl_x),
      .ctrl_y    (req_chan.ctrl_y),
      .end_x     (req_chan.end_x),
      .end_y     (req_chan.end_y),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .point_x   (rsp_chan.point_x),
      .point_y   (rsp_chan.point_y),
      .rsp_last  (rsp_chan.last)
   );

`ifndef SYNTHESIS
   // A transaction on the request side closes the request channel in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request channel still open after a transaction");

   // No request is taken while points of the previous curve are in the pipeline.
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_chan.ready)
      else $error("request channel open while the pipeline holds points");

   // Points are only issued once the step division has finished.
   a_issue_after_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.div_done)
      else $error("point issued before the step division finished");
`endif

endmodule
